/* rtl/pcps_pkg.sv */
// Shared types and constants for the pulse-count power sequencer.
package pcps_pkg;

  localparam int unsigned TimeWidthDef  = 20;
  localparam int unsigned CountWidthDef = 8;
  localparam int unsigned NumTimes      = 7;
  localparam int unsigned FuncWidth     = 2;
  localparam int unsigned OutWidth      = 8;

  localparam int unsigned OffRst       = 70;
  localparam int unsigned InitRst      = 350;
  localparam int unsigned SoftStartRst = 1000;
  localparam int unsigned HighRst      = 15;
  localparam int unsigned LowRst       = 15;
  localparam int unsigned StoreRst     = 70;
  localparam int unsigned SettleRst    = 20 * 1000;

  typedef enum logic [2:0] {
    REG_OFF        = 3'd0,
    REG_INIT       = 3'd1,
    REG_SOFT_START = 3'd2,
    REG_HIGH       = 3'd3,
    REG_LOW        = 3'd4,
    REG_STORE      = 3'd5,
    REG_SETTLE     = 3'd6,
    REG_ACTIVE_LOW = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    FN_TICK = 2'd0,
    FN_ON   = 2'd1,
    FN_OFF  = 2'd2
  } func_e;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_OFF   = 8'b0000_0010,
    PH_INIT  = 8'b0000_0100,
    PH_SS    = 8'b0000_1000,
    PH_LOW   = 8'b0001_0000,
    PH_HIGH  = 8'b0010_0000,
    PH_STORE = 8'b0100_0000,
    PH_FINAL = 8'b1000_0000
  } phase_e;

  // handshake between the input register and the sequencer core
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

/* rtl/pcps_cfg.sv */
// Configuration register file of the sequencer.
module pcps_cfg #(
  parameter int unsigned TIME_WIDTH = pcps_pkg::TimeWidthDef
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [2:0]                                  cfg_idx_i,
  input  logic [TIME_WIDTH-1:0]                       cfg_data_i,
  output logic [pcps_pkg::NumTimes-1:0][TIME_WIDTH-1:0] times_o,
  output logic                                        active_low_o
);
  import pcps_pkg::*;

  logic [NumTimes-1:0][TIME_WIDTH-1:0] times_q;
  logic                                active_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      times_q[REG_OFF]        <= TIME_WIDTH'(OffRst);
      times_q[REG_INIT]       <= TIME_WIDTH'(InitRst);
      times_q[REG_SOFT_START] <= TIME_WIDTH'(SoftStartRst);
      times_q[REG_HIGH]       <= TIME_WIDTH'(HighRst);
      times_q[REG_LOW]        <= TIME_WIDTH'(LowRst);
      times_q[REG_STORE]      <= TIME_WIDTH'(StoreRst);
      times_q[REG_SETTLE]     <= TIME_WIDTH'(SettleRst);
      active_low_q            <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_OFF:        times_q[REG_OFF]        <= cfg_data_i;
        REG_INIT:       times_q[REG_INIT]       <= cfg_data_i;
        REG_SOFT_START: times_q[REG_SOFT_START] <= cfg_data_i;
        REG_HIGH:       times_q[REG_HIGH]       <= cfg_data_i;
        REG_LOW:        times_q[REG_LOW]        <= cfg_data_i;
        REG_STORE:      times_q[REG_STORE]      <= cfg_data_i;
        REG_SETTLE:     times_q[REG_SETTLE]     <= cfg_data_i;
        REG_ACTIVE_LOW: active_low_q            <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign times_o      = times_q;
  assign active_low_o = active_low_q;

endmodule

/* rtl/pcps_in_reg.sv */
// Input register stage: captures one word per cycle while empty or while the core takes the held word.
module pcps_in_reg #(
  parameter int unsigned COUNT_WIDTH = pcps_pkg::CountWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [pcps_pkg::FuncWidth-1:0] func_i,
  input  logic [COUNT_WIDTH-1:0]         count_i,
  output pcps_pkg::hs_t                  hs_o,
  input  pcps_pkg::hs_t                  hs_i,
  output logic [pcps_pkg::FuncWidth-1:0] func_o,
  output logic [COUNT_WIDTH-1:0]         count_o
);
  import pcps_pkg::*;

  logic                   valid_q, valid_d;
  logic [FuncWidth-1:0]   func_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic                   load;

  assign ready_o = !valid_q || hs_i.ready;
  assign load    = valid_i && ready_o;
  assign valid_d = load || (valid_q && !hs_i.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      func_q  <= func_i;
      count_q <= count_i;
    end
  end

  assign hs_o.valid = valid_q;
  assign hs_o.ready = ready_o;
  assign func_o     = func_q;
  assign count_o    = count_q;

endmodule

/* rtl/pcps_core.sv */
// Sequencer state, phase stepping with zero-length skip, and result register.
module pcps_core #(
  parameter int unsigned TIME_WIDTH  = pcps_pkg::TimeWidthDef,
  parameter int unsigned COUNT_WIDTH = pcps_pkg::CountWidthDef
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  pcps_pkg::hs_t                                 hs_i,
  output pcps_pkg::hs_t                                 hs_o,
  input  logic [pcps_pkg::FuncWidth-1:0]                func_i,
  input  logic [COUNT_WIDTH-1:0]                        count_i,
  input  logic [pcps_pkg::NumTimes-1:0][TIME_WIDTH-1:0] times_i,
  input  logic                                          active_low_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output logic [pcps_pkg::OutWidth-1:0]                 out_data_o
);
  import pcps_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [TIME_WIDTH-1:0]  time_q, time_d;
  logic [COUNT_WIDTH-1:0] pulses_q, pulses_d;
  logic                   level_q, level_d;
  logic                   out_valid_q, out_valid_d;
  logic                   pin_q, busy_q, done_q, rej_q;
  logic                   done_d, rej_d;
  logic                   fire, busy, do_enter, stop;
  logic [TIME_WIDTH-1:0]  tl, store_rem;
  phase_e                 p;

  assign hs_o.ready  = !out_valid_q || out_ready_i;
  assign hs_o.valid  = out_valid_q;
  assign fire        = hs_i.valid && hs_o.ready;
  assign busy        = phase_q != PH_IDLE;
  assign store_rem   = (times_i[REG_STORE] > times_i[REG_HIGH])
                       ? times_i[REG_STORE] - times_i[REG_HIGH] : '0;
  assign out_valid_d = fire || (out_valid_q && !out_ready_i);

  always_comb begin
    phase_d  = phase_q;
    time_d   = time_q;
    pulses_d = pulses_q;
    level_d  = level_q;
    done_d   = 1'b0;
    rej_d    = 1'b0;
    do_enter = 1'b0;
    stop     = 1'b0;
    p        = PH_IDLE;
    tl       = time_q - 1'b1;
    if (fire) begin
      case (func_e'(func_i))
        FN_TICK: begin
          if (busy) begin
            time_d = tl;
            if (tl == '0) begin
              do_enter = 1'b1;
              case (phase_q)
                PH_OFF:   p = PH_INIT;
                PH_INIT:  p = PH_SS;
                PH_SS:    p = PH_LOW;
                PH_LOW:   p = PH_HIGH;
                PH_HIGH:  p = PH_LOW;
                PH_STORE: p = PH_FINAL;
                default:  p = PH_IDLE;
              endcase
            end
          end
        end
        FN_ON: begin
          if (busy) begin
            rej_d = 1'b1;
          end else begin
            pulses_d = count_i;
            do_enter = 1'b1;
            p        = PH_OFF;
          end
        end
        FN_OFF: begin
          if (busy) begin
            rej_d = 1'b1;
          end else begin
            level_d = 1'b0;
            if (times_i[REG_OFF] != '0) begin
              phase_d = PH_FINAL;
              time_d  = times_i[REG_OFF];
            end else begin
              phase_d = PH_IDLE;
              time_d  = '0;
              done_d  = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    // walk forward over zero-length phases until one with time left or the final phase
    if (do_enter) begin
      for (int i = 0; i < 8; i++) begin
        if (!stop) begin
          case (p)
            PH_OFF: begin
              level_d = 1'b0;
              if (times_i[REG_OFF] != '0) begin
                phase_d = PH_OFF; time_d = times_i[REG_OFF]; stop = 1'b1;
              end else p = PH_INIT;
            end
            PH_INIT: begin
              level_d = 1'b1;
              if (times_i[REG_INIT] != '0) begin
                phase_d = PH_INIT; time_d = times_i[REG_INIT]; stop = 1'b1;
              end else p = PH_SS;
            end
            PH_SS: begin
              if (times_i[REG_SOFT_START] != '0) begin
                phase_d = PH_SS; time_d = times_i[REG_SOFT_START]; stop = 1'b1;
              end else p = PH_LOW;
            end
            PH_LOW: begin
              if (pulses_d == '0) begin
                p = PH_STORE;
              end else if (times_i[REG_LOW] == '0 && times_i[REG_HIGH] == '0) begin
                pulses_d = '0;
                level_d  = 1'b1;
                p        = PH_STORE;
              end else begin
                pulses_d = pulses_d - 1'b1;
                level_d  = 1'b0;
                if (times_i[REG_LOW] != '0) begin
                  phase_d = PH_LOW; time_d = times_i[REG_LOW]; stop = 1'b1;
                end else p = PH_HIGH;
              end
            end
            PH_HIGH: begin
              level_d = 1'b1;
              if (times_i[REG_HIGH] != '0) begin
                phase_d = PH_HIGH; time_d = times_i[REG_HIGH]; stop = 1'b1;
              end else p = PH_LOW;
            end
            PH_STORE: begin
              if (store_rem != '0) begin
                phase_d = PH_STORE; time_d = store_rem; stop = 1'b1;
              end else p = PH_FINAL;
            end
            PH_FINAL: begin
              if (times_i[REG_SETTLE] != '0) begin
                phase_d = PH_FINAL; time_d = times_i[REG_SETTLE];
              end else begin
                phase_d = PH_IDLE; time_d = '0; done_d = 1'b1;
              end
              stop = 1'b1;
            end
            default: begin
              phase_d = PH_IDLE; time_d = '0; done_d = 1'b1; stop = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      time_q      <= '0;
      pulses_q    <= '0;
      level_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      time_q      <= time_d;
      pulses_q    <= pulses_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pin_q  <= level_d ^ active_low_i;
      busy_q <= phase_d != PH_IDLE;
      done_q <= done_d;
      rej_q  <= rej_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(OutWidth - 4){1'b0}}, rej_q, done_q, busy_q, pin_q};

`ifndef NO_ASSERTIONS
  a_busy_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE |-> time_q != '0) else $error("running phase with no time left");
  a_idle_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> time_q == '0) else $error("idle with time left");
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rej_q |-> busy_q) else $error("reject while idle");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> !busy_q && !rej_q) else $error("done while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(phase_q) && $stable(time_q)) else $error("state moved without word");
`endif

endmodule

/* rtl/pulse_count_power_sequencer_top.sv */
// Top level of the pulse-count power sequencer.
// Drives one supply enable pin by counting pulses; one tick word is one microsecond.
// Input stream: tuser carries func (tick, power-on, power-off), tdata the pulse count.
// Output stream: one result word per input word with pin level, busy, done and reject.
// Each word passes an input register, then the sequencer core and its result register:
// the result is registered once the core takes the word from the input register, and
// a new word is taken every cycle while the receiver takes the results.
// Power-on and power-off commands arriving while a sequence runs are flagged as rejected and ignored.
// Configuration writes are registered; issue them only while the block is idle.
// Reset returns the sequencer to idle with the logical level low and the
// registers to their default timings; both pipeline stages are emptied.
// When the receiver stalls, the result register holds, the input register fills,
// and s_axis_tready_o drops until the result is taken.
module pulse_count_power_sequencer_top #(
  parameter int unsigned TIME_WIDTH  = pcps_pkg::TimeWidthDef,
  parameter int unsigned COUNT_WIDTH = pcps_pkg::CountWidthDef,
  parameter int unsigned IN_WIDTH    = ((COUNT_WIDTH + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [IN_WIDTH-1:0]            s_axis_tdata_i,  // pulse_count
  input  logic [pcps_pkg::FuncWidth-1:0] s_axis_tuser_i,  // func
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [pcps_pkg::OutWidth-1:0]  m_axis_tdata_o,  // pin_level, busy_res, done_res, rejected
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_idx_i,
  input  logic [TIME_WIDTH-1:0]          cfg_data_i
);
  import pcps_pkg::*;

  logic [NumTimes-1:0][TIME_WIDTH-1:0] times;
  logic                                active_low;
  hs_t                                 in_hs, core_hs;
  logic [FuncWidth-1:0]                func;
  logic [COUNT_WIDTH-1:0]              count;

  pcps_cfg #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .times_o     (times),
    .active_low_o(active_low)
  );

  pcps_in_reg #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s_axis_tvalid_i),
    .ready_o(s_axis_tready_o),
    .func_i (s_axis_tuser_i),
    .count_i(s_axis_tdata_i[COUNT_WIDTH-1:0]),
    .hs_o   (in_hs),
    .hs_i   (core_hs),
    .func_o (func),
    .count_o(count)
  );

  pcps_core #(
    .TIME_WIDTH (TIME_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hs_i        (in_hs),
    .hs_o        (core_hs),
    .func_i      (func),
    .count_i     (count),
    .times_i     (times),
    .active_low_i(active_low),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
